// ===== src/lzw12_pkg.sv =====
`timescale 1ns / 1ps
package lzw12_pkg;

  localparam int DICT_ENTRIES   = 4096;
  localparam int MAX_STRING_LEN = 31;
  localparam int FIRST_FREE     = 256;
  localparam int CODE_W         = 12;
  localparam int NFC_W          = 13;
  localparam int LEN_W          = 5;
  localparam int HASH_W         = 13;
  localparam int SLOTS          = 8192;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } lzw_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              final_code;
  } lzw_res_t;

  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [7:0]        data_byte;
    logic [HASH_W-1:0] slot;
  } lzw_dict_t;

  // fold the 20-bit key into a table slot
  function automatic logic [HASH_W-1:0] lzw_hash(input logic [CODE_W-1:0] prefix,
                                                 input logic [7:0] b);
    lzw_hash = {1'b0, prefix} ^ {b, 5'b0} ^ {5'b0, b};
  endfunction

endpackage

// ===== src/lzw_encoder_12bit_core.sv =====
`timescale 1ns / 1ps
// LZW encoder with 12-bit codes.
// Input channel in_*: one raw byte per item on in_tdata; in_tlast marks the
// last byte of a stream. Output channel out_*: one code per item on
// out_tdata[11:0]; out_tlast marks the final code of a stream.
// A two-entry input queue takes bytes while the engine works; the engine
// looks each string extension up in an 8192-slot hash table with linear
// probing, each probe reading the slot, then the dictionary entry, and
// then comparing. A byte that needs no lookup is handled without probing;
// the final code of a stream is sent in its own state after the last byte.
// The dictionary grows to 4096 codes and is reset to the 256 single-byte
// codes after each stream. Strings are capped at 31 bytes.
// Results go into a four-entry queue; a byte is started only when two places
// are free, so a stalled receiver back-pressures the engine and then the
// input. Reset empties both queues and clears the string state; no memory
// clearing pass is needed, so items are accepted from the first cycle.
module lzw_encoder_12bit_core
  import lzw12_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [11:0] code, [15:12] zero
  output logic        out_tlast
);

  lzw_item_t in_item;
  lzw_item_t item;
  logic      item_valid;
  logic      item_pop;
  logic      space2;
  logic      res_push;
  lzw_res_t  res;
  lzw_res_t  out_res;

  assign in_item.data_byte     = in_tdata;
  assign in_item.end_of_stream = in_tlast;

  lzw12_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  lzw12_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .space2     (space2),
    .res_push   (res_push),
    .res        (res)
  );

  lzw12_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .space2    (space2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {4'b0, out_res.code};
  assign out_tlast = out_res.final_code;

endmodule

// ===== src/lzw12_front.sv =====
`timescale 1ns / 1ps
module lzw12_front
  import lzw12_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lzw_item_t in_item,
  output logic      item_valid,
  output lzw_item_t item,
  input  logic      item_pop
);

  lzw_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;

  assign in_ready   = (count_r != 2'd2);
  assign item_valid = (count_r != 2'd0);
  assign item       = mem_r[rd_ptr_r];
  assign push       = in_valid && in_ready;
  assign pop        = item_pop && item_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ===== src/lzw12_outq.sv =====
`timescale 1ns / 1ps
module lzw12_outq
  import lzw12_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     res_push,
  input  lzw_res_t res,
  output logic     space2,
  output logic     out_valid,
  input  logic     out_ready,
  output lzw_res_t out_res
);

  lzw_res_t   mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign space2    = (count_r <= 3'd2);
  assign out_valid = (count_r != 3'd0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = res_push ? wr_ptr_r + 2'd1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 2'd1 : rd_ptr_r;
    count_nxt  = count_r + {2'b0, res_push} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      mem_r[wr_ptr_r] <= res;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (count_r != 3'd4 || pop))
    else $error("result queue overflow");

endmodule

// ===== src/lzw12_back.sv =====
`timescale 1ns / 1ps
module lzw12_back
  import lzw12_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  input  lzw_item_t item,
  output logic      item_pop,
  input  logic      space2,
  output logic      res_push,
  output lzw_res_t  res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SLOT = 3'd1;
  localparam logic [2:0] S_DICT = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [NFC_W-1:0]  nfc_r, nfc_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic [HASH_W-1:0] probe_r, probe_nxt;
  logic [CODE_W-1:0] slot_q_r;
  lzw_dict_t         dict_q_r;
  logic              we;
  logic              live;

  logic [CODE_W-1:0] slot_mem [SLOTS];
  lzw_dict_t         dict_mem [DICT_ENTRIES];

  // a slot is live only if it points at an entry in use that points back at it
  assign live = (slot_q_r >= CODE_W'(FIRST_FREE)) && ({1'b0, slot_q_r} < nfc_r) &&
                (dict_q_r.slot == probe_r);

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    len_nxt   = len_r;
    nfc_nxt   = nfc_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    probe_nxt = probe_r;
    item_pop  = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    we        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (item_valid && space2) begin
          item_pop = 1'b1;
          byte_nxt = item.data_byte;
          last_nxt = item.end_of_stream;
          if (len_r == '0) begin
            code_nxt  = {4'b0, item.data_byte};
            len_nxt   = LEN_W'(1);
            state_nxt = item.end_of_stream ? S_FIN : S_IDLE;
          end else if (len_r >= LEN_W'(MAX_STRING_LEN)) begin
            res_push  = 1'b1;
            res.code  = code_r;
            code_nxt  = {4'b0, item.data_byte};
            len_nxt   = LEN_W'(1);
            state_nxt = item.end_of_stream ? S_FIN : S_IDLE;
          end else begin
            probe_nxt = lzw_hash(code_r, item.data_byte);
            state_nxt = S_SLOT;
          end
        end
      end
      S_SLOT: state_nxt = S_DICT;
      S_DICT: state_nxt = S_CMP;
      S_CMP: begin
        if (live && dict_q_r.prefix == code_r && dict_q_r.data_byte == byte_r) begin
          code_nxt  = slot_q_r;
          len_nxt   = len_r + LEN_W'(1);
          state_nxt = last_r ? S_FIN : S_IDLE;
        end else if (live) begin
          probe_nxt = probe_r + HASH_W'(1);
          state_nxt = S_SLOT;
        end else begin
          res_push = 1'b1;
          res.code = code_r;
          if (nfc_r < NFC_W'(DICT_ENTRIES)) begin
            we      = 1'b1;
            nfc_nxt = nfc_r + NFC_W'(1);
          end
          code_nxt  = {4'b0, byte_r};
          len_nxt   = LEN_W'(1);
          state_nxt = last_r ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        res_push       = 1'b1;
        res.code       = code_r;
        res.final_code = 1'b1;
        code_nxt       = '0;
        len_nxt        = '0;
        nfc_nxt        = NFC_W'(FIRST_FREE);
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= '0;
      len_r   <= '0;
      nfc_r   <= NFC_W'(FIRST_FREE);
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      len_r   <= len_nxt;
      nfc_r   <= nfc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
    probe_r <= probe_nxt;
  end

  // hash slots and dictionary: one write and one registered read each
  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem[probe_r] <= nfc_r[CODE_W-1:0];
    end
    slot_q_r <= slot_mem[probe_r];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      dict_mem[nfc_r[CODE_W-1:0]] <= '{prefix: code_r, data_byte: byte_r, slot: probe_r};
    end
    dict_q_r <= dict_mem[slot_q_r];
  end

  a_nfc_range: assert property (@(posedge clk) disable iff (!rst_n)
    nfc_r >= NFC_W'(FIRST_FREE) && nfc_r <= NFC_W'(DICT_ENTRIES))
    else $error("free code out of range");

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_STRING_LEN))
    else $error("string length over cap");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> len_r == '0 && nfc_r == NFC_W'(FIRST_FREE))
    else $error("end of stream did not clear state");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> state_r == S_IDLE && space2)
    else $error("item taken while busy or without room");

endmodule
